// File: hdl/dtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared types, character codes and lookup functions of the date-time text
// parser.
// ----------------------------------------------------------------------------
package dtp_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } dtp_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [33:0] unix_seconds;
    logic [13:0] year_value;
    logic [7:0]  month_value;
    logic [7:0]  day_value;
    logic [7:0]  hour_value;
    logic [7:0]  minute_value;
    logic [7:0]  second_value;
    logic        zone_given;
    logic        zone_negative;
    logic [7:0]  zone_hours;
    logic [7:0]  zone_minutes;
  } dtp_out_t;

  // Result status codes.
  localparam logic [1:0] ST_PARTS = 2'd0;
  localparam logic [1:0] ST_STAMP = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam int unsigned RUN_MAX = 14;

  localparam logic [13:0] PIVOT_YEAR  = 14'd70;
  localparam logic [13:0] CENTURY_OLD = 14'd1900;
  localparam logic [13:0] CENTURY_NEW = 14'd2000;
  localparam logic [7:0]  CTRL_LIMIT  = 8'h20;
  localparam logic [7:0]  CASE_BIT    = 8'h20;
  localparam logic [7:0]  PM_SHIFT    = 8'd12;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UPPER_T = 8'h54;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_M = 8'h6D;
  localparam logic [7:0] CH_LOWER_P = 8'h70;

  // Word codes: 1 to 12 are months.
  localparam logic [4:0] WC_NONE  = 5'd0;
  localparam logic [4:0] WC_MONTH_LAST = 5'd12;
  localparam logic [4:0] WC_UTC   = 5'd13;
  localparam logic [4:0] WC_MSK   = 5'd14;
  localparam logic [4:0] WC_MSD   = 5'd15;
  localparam logic [4:0] WC_WEEKDAY = 5'd16;

  function automatic logic [4:0] word_code(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c);
    logic [23:0] w;
    logic [4:0]  code;
    w = {a | CASE_BIT, b | CASE_BIT, c | CASE_BIT};
    unique case (w)
      "jan": code = 5'd1;
      "feb": code = 5'd2;
      "mar": code = 5'd3;
      "apr": code = 5'd4;
      "may": code = 5'd5;
      "jun": code = 5'd6;
      "jul": code = 5'd7;
      "aug": code = 5'd8;
      "sep": code = 5'd9;
      "oct": code = 5'd10;
      "nov": code = 5'd11;
      "dec": code = 5'd12;
      "utc", "gmt": code = WC_UTC;
      "msk": code = WC_MSK;
      "msd": code = WC_MSD;
      "mon", "tue", "wed", "thu", "fri", "sat", "sun": code = WC_WEEKDAY;
      default: code = WC_NONE;
    endcase
    return code;
  endfunction

  // Two decimal digits to their value.
  function automatic logic [6:0] pair_val(input logic [3:0] hi, input logic [3:0] lo);
    return 7'({hi, 3'b000}) + 7'({hi, 1'b0}) + 7'(lo);
  endfunction

endpackage

// File: hdl/dtp_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface dtp_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// File: hdl/datetime_text_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datetime_text_parser_unit
// Byte-serial date-time text parser with one result per text.
// ----------------------------------------------------------------------------
// The parser takes one text byte in every cycle unless input is held off: each
// byte is handled by one pass of logic between the parse state registers and the
// result register, so the next text may start right after its final byte. The
// result of a text appears in the cycle after the transfer of its final byte and
// sits in a single output register; input is held off only while that register
// holds a result that has not been taken.
module datetime_text_parser_unit (
  input  logic              clk,
  input  logic              rst,
  dtp_chan_if.sink          text,
  dtp_chan_if.source        result
);
  import dtp_pkg::*;

  typedef enum logic [4:0] {
    PH_TOKEN, PH_MAIN, PH_YM, PH_YMD, PH_HM, PH_HMS, PH_DM, PH_DMY, PH_TZ, PH_TZM,
    PH_FRAC, PH_ALPHA, PH_SKIP, PH_SKIPDOW, PH_DONE, PH_STAMP, PH_ERR
  } phase_t;

  typedef struct packed {
    logic [13:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic [7:0]  zone_h;
    logic [7:0]  zone_m;
    logic        time_seen;
    logic        zone;
    logic        neg;
    logic        pm;
  } comp_t;

  function automatic logic is_run_phase(input phase_t p);
    return (p == PH_MAIN) || (p == PH_YM) || (p == PH_YMD) || (p == PH_HM) ||
           (p == PH_HMS) || (p == PH_DM) || (p == PH_DMY) || (p == PH_TZ) ||
           (p == PH_TZM) || (p == PH_FRAC);
  endfunction

  function automatic logic is_ampm(input logic [1:0] n, input logic [7:0] l0,
                                   input logic [7:0] l1);
    return (n == 2'd2) && ((l1 | CASE_BIT) == CH_LOWER_M) &&
           (((l0 | CASE_BIT) == CH_LOWER_A) || ((l0 | CASE_BIT) == CH_LOWER_P));
  endfunction

  // Registers.
  phase_t      phase, phase_next;
  logic [3:0]  dg [RUN_MAX];
  logic [3:0]  dg_next [RUN_MAX];
  logic [3:0]  run_cnt, run_cnt_next;
  logic [33:0] run_acc, run_acc_next;
  logic [7:0]  letters [3];
  logic [7:0]  letters_next [3];
  logic [1:0]  lc, lc_next;
  logic [7:0]  delim, delim_next;
  comp_t       comp, comp_next;
  dtp_out_t    res, res_next;
  logic        res_valid;

  logic [7:0]  c;
  logic        fin, c_digit, c_alpha, in_ready, accept;
  logic        run_now, start_run, fire_byte, fire_lim;
  logic [3:0]  run_cnt_post;
  logic [33:0] run_acc_post;

  assign c       = text.payload.text_byte;
  assign fin     = text.payload.final_byte;
  assign c_digit = (c >= 8'h30) && (c <= 8'h39);
  assign c_alpha = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  assign in_ready = !res_valid || result.ready;
  assign accept  = text.valid && in_ready;
  assign text.ready     = in_ready;
  assign result.valid   = res_valid;
  assign result.payload = res;

  assign run_now = is_run_phase(phase);
  // A digit opens a run from the token phase, or after a word or an AM/PM
  // marker hands the byte on to the token phase.
  assign start_run = c_digit && ((comp.year == 14'd0) || !comp.time_seen) &&
                     ((phase == PH_TOKEN) || (phase == PH_SKIP) || (phase == PH_SKIPDOW) ||
                      ((phase == PH_ALPHA) && is_ampm(lc, letters[0], letters[1])));
  assign fire_byte = run_now && !c_digit;
  assign fire_lim  = run_now && c_digit && (run_cnt == 4'(RUN_MAX - 1));

  // Digit run update for this byte.
  always_comb begin
    dg_next      = dg;
    run_cnt_post = run_cnt;
    run_acc_post = run_acc;
    if (start_run) begin
      dg_next[0]   = c[3:0];
      run_cnt_post = 4'd1;
      run_acc_post = 34'(c[3:0]);
    end else if (run_now && c_digit) begin
      dg_next[run_cnt] = c[3:0];
      run_cnt_post     = run_cnt + 4'd1;
      run_acc_post     = {run_acc[30:0], 3'b000} + {run_acc[32:0], 1'b0} + 34'(c[3:0]);
    end
  end

  // Closing of a digit run. At most one run closes per byte, either on the
  // delimiter byte, at the length limit, or at the end of the text.
  phase_t      er_phase;
  comp_t       er_comp;
  logic [7:0]  er_delim;
  logic        er_used;

  always_comb begin : run_close
    phase_t      rp;
    logic [3:0]  n;
    logic [6:0]  p0, p1, p2, p3, p4, p5, p6, q1;
    logic [13:0] f4;
    logic [7:0]  sv;
    logic        short_run, y, t, la_colon, la_slash, la_delim, la_stop;
    rp        = start_run ? PH_MAIN : phase;
    n         = run_cnt_post;
    p0        = pair_val(dg_next[0], dg_next[1]);
    p1        = pair_val(dg_next[2], dg_next[3]);
    p2        = pair_val(dg_next[4], dg_next[5]);
    p3        = pair_val(dg_next[6], dg_next[7]);
    p4        = pair_val(dg_next[8], dg_next[9]);
    p5        = pair_val(dg_next[10], dg_next[11]);
    p6        = pair_val(dg_next[12], dg_next[13]);
    q1        = pair_val(dg_next[1], dg_next[2]);
    f4        = 14'(p0) * 14'd100 + 14'(p1);
    short_run = (n == 4'd1) || (n == 4'd2);
    sv        = (n == 4'd1) ? 8'(dg_next[0]) : 8'(p0);
    y         = comp.year != 14'd0;
    t         = comp.time_seen;
    la_colon  = fire_byte && (c == CH_COLON);
    la_slash  = fire_byte && (c == CH_SLASH);
    la_delim  = fire_byte && (c == delim);
    la_stop   = fire_byte && ((c < CTRL_LIMIT) || c[7] || (c == CH_COMMA) ||
                              (c == CH_SEMI) || (c == CH_QUOTE) || (c == CH_DQUOTE));
    er_comp   = comp;
    // A PM marker that hands its byte to a new run is taken in the same pass.
    er_comp.pm = comp.pm || (start_run && (phase == PH_ALPHA) &&
                             ((letters[0] | CASE_BIT) == CH_LOWER_P));
    er_delim  = delim;
    er_phase  = PH_TOKEN;
    er_used   = 1'b0;
    unique case (rp)
      PH_MAIN: begin
        priority if (((n == 4'd10) || (n == 4'd9)) && !y && !t) begin
          er_phase = PH_STAMP;
          er_used  = 1'b1;
        end else if ((n == 4'd14) && !y && !t) begin
          er_comp.year      = f4;
          er_comp.month     = comp.month + 8'(p2);
          er_comp.day       = comp.day + 8'(p3);
          er_comp.hour      = comp.hour + 8'(p4);
          er_comp.minute    = comp.minute + 8'(p5);
          er_comp.second    = comp.second + 8'(p6);
          er_comp.time_seen = 1'b1;
        end else if ((n == 4'd8) && !y) begin
          er_comp.year  = f4;
          er_comp.month = comp.month + 8'(p2);
          er_comp.day   = comp.day + 8'(p3);
        end else if (n == 4'd6) begin
          if (!y && (comp.month == 8'd0)) begin
            er_comp.year  = f4;
            er_comp.month = comp.month + 8'(p2);
          end else if (!t) begin
            er_comp.hour      = comp.hour + 8'(p0);
            er_comp.minute    = comp.minute + 8'(p1);
            er_comp.second    = comp.second + 8'(p2);
            er_comp.time_seen = 1'b1;
          end else begin
            er_phase = PH_ERR;
            er_used  = 1'b1;
          end
        end else if ((n == 4'd4) && !y) begin
          er_comp.year = f4;
          if (!fire_byte) begin
            er_phase = PH_TOKEN;
          end else if (la_stop) begin
            er_phase = PH_DONE;
            er_used  = 1'b1;
          end else if (comp.month == 8'd0) begin
            er_delim = c;
            er_phase = PH_YM;
            er_used  = 1'b1;
          end
        end else if (short_run) begin
          if (la_colon) begin
            er_used = 1'b1;
            if (t) begin
              er_phase = PH_ERR;
            end else begin
              er_comp.hour      = sv;
              er_comp.time_seen = 1'b1;
              er_phase          = PH_HM;
            end
          end else if (la_slash) begin
            er_used = 1'b1;
            if ((comp.day != 8'd0) || (comp.month != 8'd0)) begin
              er_phase = PH_ERR;
            end else begin
              er_comp.day = sv;
              er_phase    = PH_DM;
            end
          end else if (comp.day != 8'd0) begin
            er_comp.hour = sv;
          end else begin
            er_comp.day = sv;
          end
        end else begin
          er_phase = PH_ERR;
          er_used  = 1'b1;
        end
      end
      PH_YM, PH_YMD: begin
        if (short_run) begin
          if (rp == PH_YM) begin
            er_comp.month = comp.month + sv;
            if ((comp.day == 8'd0) && la_delim) begin
              er_phase = PH_YMD;
              er_used  = 1'b1;
            end
          end else begin
            er_comp.day = comp.day + sv;
          end
        end else if (delim != CH_SPACE) begin
          er_phase = PH_ERR;
          er_used  = 1'b1;
        end
      end
      PH_HM, PH_HMS, PH_DM, PH_TZM: begin
        if (!short_run) begin
          er_phase = PH_ERR;
          er_used  = 1'b1;
        end else begin
          unique case (rp)
            PH_HM: begin
              er_comp.minute = comp.minute + sv;
              if (la_colon) begin
                er_phase = PH_HMS;
                er_used  = 1'b1;
              end
            end
            PH_HMS: er_comp.second = comp.second + sv;
            PH_DM: begin
              er_comp.month = comp.month + sv;
              if (la_slash) begin
                er_used  = 1'b1;
                er_phase = y ? PH_ERR : PH_DMY;
              end
            end
            default: er_comp.zone_m = comp.zone_m + sv;
          endcase
        end
      end
      PH_DMY: begin
        if (n == 4'd4) begin
          er_comp.year = f4;
        end else if (n == 4'd2) begin
          er_comp.year = (14'(p0) >= PIVOT_YEAR) ? 14'(p0) + CENTURY_OLD
                                                 : 14'(p0) + CENTURY_NEW;
        end else begin
          er_phase = PH_ERR;
          er_used  = 1'b1;
        end
      end
      PH_TZ: begin
        if (n == 4'd4) begin
          er_comp.zone_h = comp.zone_h + 8'(p0);
          er_comp.zone_m = comp.zone_m + 8'(p1);
        end else if (n == 4'd3) begin
          er_comp.zone_h = comp.zone_h + 8'(dg_next[0]);
          er_comp.zone_m = comp.zone_m + 8'(q1);
        end else if (short_run) begin
          er_comp.zone_h = comp.zone_h + sv;
        end else begin
          er_phase = PH_ERR;
          er_used  = 1'b1;
        end
        if ((er_phase != PH_ERR) && short_run && la_colon) begin
          er_phase = PH_TZM;
          er_used  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // One byte through the parse state, then the end of text when flagged.
  always_comb begin : step
    phase_t     ph;
    comp_t      cp;
    logic       to_tok;
    logic [4:0] code;
    logic [7:0] hr;
    ph           = phase;
    cp           = comp;
    to_tok       = 1'b0;
    code         = WC_NONE;
    hr           = 8'd0;
    delim_next   = delim;
    letters_next = letters;
    lc_next      = lc;
    run_cnt_next = run_cnt_post;
    run_acc_next = run_acc_post;
    res_next     = res;

    unique case (phase)
      PH_TOKEN: to_tok = 1'b1;
      PH_MAIN, PH_YM, PH_YMD, PH_HM, PH_HMS, PH_DM, PH_DMY, PH_TZ, PH_TZM,
      PH_FRAC: begin
        if (!c_digit || fire_lim) begin
          ph           = er_phase;
          cp           = er_comp;
          delim_next   = er_delim;
          run_cnt_next = 4'd0;
          to_tok       = !c_digit && !er_used;
        end
      end
      PH_ALPHA: begin
        if (c_alpha) begin
          if (lc == 2'd2) begin
            code    = word_code(letters[0], letters[1], c);
            lc_next = 2'd3;
            ph      = PH_SKIP;
            priority if (code == WC_NONE) begin
              ph = PH_ERR;
            end else if (code <= WC_MONTH_LAST) begin
              cp.month = 8'(code);
            end else if (code == WC_UTC) begin
              cp.zone = 1'b1;
            end else if (code == WC_MSK) begin
              cp.zone   = 1'b1;
              cp.zone_h = 8'd3;
            end else if (code == WC_MSD) begin
              cp.zone   = 1'b1;
              cp.zone_h = 8'd4;
            end else begin
              ph = PH_SKIPDOW;
            end
          end else begin
            letters_next[lc] = c;
            lc_next          = lc + 2'd1;
          end
        end else if (is_ampm(lc, letters[0], letters[1])) begin
          cp.pm  = comp.pm || ((letters[0] | CASE_BIT) == CH_LOWER_P);
          to_tok = 1'b1;
        end else begin
          ph = PH_ERR;
        end
      end
      PH_SKIP, PH_SKIPDOW: begin
        if (!c_alpha) begin
          if ((phase == PH_SKIPDOW) && (c == CH_COMMA)) begin
            ph = PH_TOKEN;
          end else begin
            to_tok = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (to_tok) begin
      ph = PH_TOKEN;
      priority if (start_run) begin
        ph = PH_MAIN;
      end else if ((c == CH_SPACE) || (c == CH_UPPER_T)) begin
        ph = PH_TOKEN;
      end else if (c == CH_UPPER_Z) begin
        cp.zone = 1'b1;
      end else if (c == CH_POINT) begin
        if (!cp.time_seen) begin
          ph = PH_ERR;
        end else begin
          run_cnt_next = 4'd0;
          ph           = PH_FRAC;
        end
      end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
        cp.zone      = 1'b1;
        cp.neg       = cp.neg || (c == CH_MINUS);
        run_cnt_next = 4'd0;
        ph           = PH_TZ;
      end else if (c_alpha) begin
        letters_next[0] = c;
        lc_next         = 2'd1;
        ph              = PH_ALPHA;
      end else begin
        ph = PH_DONE;
      end
    end

    if (fin) begin
      unique case (ph)
        PH_MAIN, PH_YM, PH_YMD, PH_HM, PH_HMS, PH_DM, PH_DMY, PH_TZ, PH_TZM,
        PH_FRAC: begin
          if (run_cnt_next != 4'd0) begin
            ph = er_phase;
            cp = er_comp;
          end else begin
            // An empty run left open by the last delimiter.
            unique case (ph)
              PH_YM, PH_YMD: ph = (delim_next == CH_SPACE) ? PH_TOKEN : PH_ERR;
              PH_FRAC:       ph = PH_TOKEN;
              default:       ph = PH_ERR;
            endcase
          end
        end
        PH_ALPHA: begin
          if (is_ampm(lc_next, letters_next[0], letters_next[1])) begin
            cp.pm = cp.pm || ((letters_next[0] | CASE_BIT) == CH_LOWER_P);
            ph    = PH_TOKEN;
          end else begin
            ph = PH_ERR;
          end
        end
        default: ;
      endcase

      res_next = '0;
      if (ph == PH_ERR) begin
        res_next.status = ST_ERROR;
      end else if (ph == PH_STAMP) begin
        res_next.status       = ST_STAMP;
        res_next.unix_seconds = run_acc_post;
      end else begin
        hr = cp.hour;
        if (cp.pm && (hr < PM_SHIFT)) begin
          hr = hr + PM_SHIFT;
        end
        res_next.status        = ST_PARTS;
        res_next.year_value    = (cp.year != 14'd0) ? cp.year : CENTURY_NEW;
        res_next.month_value   = (cp.month != 8'd0) ? cp.month : 8'd1;
        res_next.day_value     = (cp.day != 8'd0) ? cp.day : 8'd1;
        res_next.hour_value    = hr;
        res_next.minute_value  = cp.minute;
        res_next.second_value  = cp.second;
        res_next.zone_given    = cp.zone;
        res_next.zone_negative = cp.neg;
        res_next.zone_hours    = cp.zone_h;
        res_next.zone_minutes  = cp.zone_m;
      end

      // Back to the reset state for the next text.
      ph           = PH_TOKEN;
      cp           = '0;
      delim_next   = 8'd0;
      lc_next      = 2'd0;
      run_cnt_next = 4'd0;
      run_acc_next = 34'd0;
    end

    phase_next = ph;
    comp_next  = cp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_TOKEN;
      run_cnt   <= 4'd0;
      run_acc   <= 34'd0;
      lc        <= 2'd0;
      delim     <= 8'd0;
      comp      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase   <= phase_next;
        run_cnt <= run_cnt_next;
        run_acc <= run_acc_next;
        lc      <= lc_next;
        delim   <= delim_next;
        comp    <= comp_next;
      end
      if (accept && fin) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
    if (accept) begin
      dg      <= dg_next;
      letters <= letters_next;
    end
    if (accept && fin) begin
      res <= res_next;
    end
  end

`ifndef ASSERT_OFF
  a_result_follows_final: assert property (@(posedge clk) disable iff (rst)
    accept && fin |=> res_valid)
    else $error("final byte transfer did not load a result");

  a_reset_after_final: assert property (@(posedge clk) disable iff (rst)
    accept && fin |=> (phase == PH_TOKEN) && (run_cnt == 4'd0) && (comp == '0))
    else $error("parse state not cleared after final byte");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.status == ST_PARTS) || (res.status == ST_STAMP) ||
                  (res.status == ST_ERROR))
    else $error("undefined result status");

  a_stamp_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == ST_STAMP) |-> (res.year_value == 14'd0) &&
                                              (res.month_value == 8'd0))
    else $error("timestamp result carries component fields");

  a_run_length: assert property (@(posedge clk) disable iff (rst)
    run_cnt < 4'(RUN_MAX))
    else $error("digit run exceeded its limit");
`endif

endmodule

// File: tb/sv/datetime_text_parser_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datetime_text_parser_unit_test
// Self-checking bench for the byte-serial date-time text parser. Directed
// texts cover the named corner cases, then random well-formed, corrupted and
// noise texts run under several idle and stall patterns. A behavioral parser
// kept in step with every accepted byte predicts each result, and the results
// are checked field by field as they are transferred.
// ----------------------------------------------------------------------------
module datetime_text_parser_unit_test;
  import dtp_pkg::*;

  typedef enum logic [4:0] {
    S_TOKEN, S_MAIN, S_YM, S_YMD, S_HM, S_HMS, S_DM, S_DMY, S_TZ, S_TZM,
    S_FRAC, S_ALPHA, S_SKIP, S_SKIPDOW, S_DONE, S_STAMP, S_ERR
  } scan_state_e;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_BYTES = 360;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dtp_chan_if #(.payload_t(dtp_in_t))  text_ch();
  dtp_chan_if #(.payload_t(dtp_out_t)) result_ch();

  datetime_text_parser_unit i_dut (
    .clk(clk),
    .rst(rst),
    .text(text_ch.sink),
    .result(result_ch.source)
  );

  always #1 clk = ~clk;

  dtp_in_t     byte_queue[$];
  dtp_out_t    due_results[$];
  logic [7:0]  text_buf[$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  long_stall_req = 1'b0;
  int  hold_cnt = 0;
  int  error_count = 0;
  int  idle_cycles = 0;
  int  texts_sent = 0;
  int  bytes_sent = 0;
  int  results_seen = 0;
  int  stamps_seen = 0;
  int  errors_seen = 0;

  // Shadow parser state.
  scan_state_e scan_state;
  logic [3:0]  digs[14];
  int          ndig;
  logic [7:0]  lets[3];
  int          nlet;
  int          delim;
  logic [31:0] yr;
  logic [7:0]  mon, dday, hr, mnt, sec, zh, zm;
  bit          f_time, f_zone, f_neg, f_pm;
  logic [63:0] stamp;

  function automatic void clear_parser();
    scan_state = S_TOKEN;
    for (int i = 0; i < 14; i++) digs[i] = '0;
    for (int i = 0; i < 3; i++) lets[i] = '0;
    ndig = 0;
    nlet = 0;
    delim = 0;
    yr = '0;
    {mon, dday, hr, mnt, sec, zh, zm} = '0;
    {f_time, f_zone, f_neg, f_pm} = '0;
    stamp = '0;
  endfunction

  function automatic bit is_dig(int c);
    return c >= 48 && c <= 57;
  endfunction

  function automatic bit is_let(int c);
    return (c >= 65 && c <= 90) || (c >= 97 && c <= 122);
  endfunction

  function automatic logic [63:0] run_value(int start, int len);
    logic [63:0] v;
    v = 0;
    for (int i = 0; i < len; i++)
      v = v * 10 + ((start + i) < 14 ? digs[start + i] : 0);
    return v;
  endfunction

  function automatic logic [7:0] wrap_add(logic [7:0] a, logic [63:0] b);
    return 8'(a + b);
  endfunction

  function automatic bit give_up();
    scan_state = S_ERR;
    return 1'b1;
  endfunction

  function automatic bit next_token();
    scan_state = S_TOKEN;
    return 1'b0;
  endfunction

  // Places a digit run of the opening token by its length and lookahead.
  function automatic bit place_first_run(int n, int la);
    bit y, t;
    logic [7:0] v;
    y = yr != 0;
    t = f_time;
    if ((n == 10 || n == 9) && !y && !t) begin
      stamp = run_value(0, n);
      scan_state = S_STAMP;
      return 1'b1;
    end
    if (n == 14 && !y && !t) begin
      yr = 32'(run_value(0, 4));
      mon = wrap_add(mon, run_value(4, 2));
      dday = wrap_add(dday, run_value(6, 2));
      hr = wrap_add(hr, run_value(8, 2));
      mnt = wrap_add(mnt, run_value(10, 2));
      sec = wrap_add(sec, run_value(12, 2));
      f_time = 1'b1;
      return next_token();
    end
    if (n == 8 && !y) begin
      yr = 32'(run_value(0, 4));
      mon = wrap_add(mon, run_value(4, 2));
      dday = wrap_add(dday, run_value(6, 2));
      return next_token();
    end
    if (n == 6) begin
      if (!y && mon == 0) begin
        yr = 32'(run_value(0, 4));
        mon = wrap_add(mon, run_value(4, 2));
        return next_token();
      end
      if (!t) begin
        hr = wrap_add(hr, run_value(0, 2));
        mnt = wrap_add(mnt, run_value(2, 2));
        sec = wrap_add(sec, run_value(4, 2));
        f_time = 1'b1;
        return next_token();
      end
      return give_up();
    end
    if (n == 4 && !y) begin
      yr = 32'(run_value(0, 4));
      if (la < 0) return next_token();
      if (la < CTRL_LIMIT || la >= 8'h80 || la == CH_COMMA || la == CH_SEMI ||
          la == CH_QUOTE || la == CH_DQUOTE) begin
        scan_state = S_DONE;
        return 1'b1;
      end
      if (mon != 0) return next_token();
      delim = la;
      scan_state = S_YM;
      return 1'b1;
    end
    if (n == 1 || n == 2) begin
      v = 8'(run_value(0, n));
      if (la == CH_COLON) begin
        if (t) return give_up();
        hr = v;
        f_time = 1'b1;
        scan_state = S_HM;
        return 1'b1;
      end
      if (la == CH_SLASH) begin
        if (dday != 0 || mon != 0) return give_up();
        dday = v;
        scan_state = S_DM;
        return 1'b1;
      end
      if (dday != 0) hr = v;
      else dday = v;
      return next_token();
    end
    return give_up();
  endfunction

  // la is the next byte, -1 at end of text, -2 when the run hit its limit.
  function automatic bit close_run(int la);
    int n;
    bit short_run;
    logic [63:0] v;
    n = ndig;
    short_run = (n == 1 || n == 2);
    v = run_value(0, n < 14 ? n : 14);
    ndig = 0;
    case (scan_state)
      S_MAIN: return place_first_run(n, la);
      S_YM: begin
        if (short_run) begin
          mon = wrap_add(mon, v);
          if (dday == 0 && la == delim) begin
            scan_state = S_YMD;
            return 1'b1;
          end
          return next_token();
        end
        return delim == CH_SPACE ? next_token() : give_up();
      end
      S_YMD: begin
        if (short_run) begin
          dday = wrap_add(dday, v);
          return next_token();
        end
        return delim == CH_SPACE ? next_token() : give_up();
      end
      S_HM: begin
        if (!short_run) return give_up();
        mnt = wrap_add(mnt, v);
        if (la == CH_COLON) begin
          scan_state = S_HMS;
          return 1'b1;
        end
        return next_token();
      end
      S_HMS: begin
        if (!short_run) return give_up();
        sec = wrap_add(sec, v);
        return next_token();
      end
      S_DM: begin
        if (!short_run) return give_up();
        mon = wrap_add(mon, v);
        if (la == CH_SLASH) begin
          if (yr != 0) return give_up();
          scan_state = S_DMY;
          return 1'b1;
        end
        return next_token();
      end
      S_DMY: begin
        if (n == 4) yr = 32'(v);
        else if (n == 2) yr = 32'(v >= PIVOT_YEAR ? v + CENTURY_OLD : v + CENTURY_NEW);
        else return give_up();
        return next_token();
      end
      S_TZ: begin
        if (n == 4) begin
          zh = wrap_add(zh, run_value(0, 2));
          zm = wrap_add(zm, run_value(2, 2));
        end else if (n == 3) begin
          zh = wrap_add(zh, run_value(0, 1));
          zm = wrap_add(zm, run_value(1, 2));
        end else if (short_run) begin
          zh = wrap_add(zh, v);
        end else begin
          return give_up();
        end
        if (n < 3 && la == CH_COLON) begin
          scan_state = S_TZM;
          return 1'b1;
        end
        return next_token();
      end
      S_TZM: begin
        if (!short_run) return give_up();
        zm = wrap_add(zm, v);
        return next_token();
      end
      default: return next_token();
    endcase
  endfunction

  function automatic void lookup_word();
    logic [23:0] w;
    w = {lets[0] | CASE_BIT, lets[1] | CASE_BIT, lets[2] | CASE_BIT};
    scan_state = S_SKIP;
    case (w)
      "jan": mon = 8'd1;
      "feb": mon = 8'd2;
      "mar": mon = 8'd3;
      "apr": mon = 8'd4;
      "may": mon = 8'd5;
      "jun": mon = 8'd6;
      "jul": mon = 8'd7;
      "aug": mon = 8'd8;
      "sep": mon = 8'd9;
      "oct": mon = 8'd10;
      "nov": mon = 8'd11;
      "dec": mon = 8'd12;
      "utc", "gmt": f_zone = 1'b1;
      "msk": begin f_zone = 1'b1; zh = 8'd3; end
      "msd": begin f_zone = 1'b1; zh = 8'd4; end
      "mon", "tue", "wed", "thu", "fri", "sat", "sun": scan_state = S_SKIPDOW;
      default: scan_state = S_ERR;
    endcase
  endfunction

  // Offers one byte (-1 for end of text); returns 1 when it was consumed.
  function automatic bit offer_byte(int c);
    int f;
    case (scan_state)
      S_TOKEN: begin
        if (c < 0) return 1'b1;
        if (is_dig(c) && (yr == 0 || !f_time)) begin
          digs[0] = 4'(c - 48);
          ndig = 1;
          scan_state = S_MAIN;
        end else if (c == CH_SPACE || c == CH_UPPER_T) begin
        end else if (c == CH_UPPER_Z) begin
          f_zone = 1'b1;
        end else if (c == CH_POINT) begin
          if (!f_time) return give_up();
          ndig = 0;
          scan_state = S_FRAC;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          f_zone = 1'b1;
          if (c == CH_MINUS) f_neg = 1'b1;
          ndig = 0;
          scan_state = S_TZ;
        end else if (is_let(c)) begin
          lets[0] = 8'(c);
          nlet = 1;
          scan_state = S_ALPHA;
        end else begin
          scan_state = S_DONE;
        end
        return 1'b1;
      end
      S_MAIN, S_YM, S_YMD, S_HM, S_HMS, S_DM, S_DMY, S_TZ, S_TZM, S_FRAC: begin
        if (is_dig(c)) begin
          if (ndig < 14) digs[ndig] = 4'(c - 48);
          ndig++;
          if (ndig >= 14) void'(close_run(-2));
          return 1'b1;
        end
        return close_run(c);
      end
      S_ALPHA: begin
        if (is_let(c)) begin
          if (nlet < 3) lets[nlet] = 8'(c);
          nlet++;
          if (nlet >= 3) lookup_word();
          return 1'b1;
        end
        if (nlet == 2 && (lets[1] | CASE_BIT) == CH_LOWER_M) begin
          f = lets[0] | CASE_BIT;
          if (f == CH_LOWER_A) return next_token();
          if (f == CH_LOWER_P) begin
            f_pm = 1'b1;
            return next_token();
          end
        end
        return give_up();
      end
      S_SKIP, S_SKIPDOW: begin
        if (c < 0 || is_let(c)) return 1'b1;
        if (scan_state == S_SKIPDOW && c == CH_COMMA) begin
          scan_state = S_TOKEN;
          return 1'b1;
        end
        return next_token();
      end
      default: return 1'b1;
    endcase
  endfunction

  function automatic void predict_parse(dtp_in_t item);
    dtp_out_t r;
    logic [7:0] h;
    for (int k = 0; k < 4; k++)
      if (offer_byte(item.text_byte)) break;
    if (!item.final_byte) return;
    void'(offer_byte(-1));
    r = '0;
    if (scan_state == S_ERR) begin
      r.status = ST_ERROR;
    end else if (scan_state == S_STAMP) begin
      r.status = ST_STAMP;
      r.unix_seconds = stamp[33:0];
    end else begin
      h = hr;
      if (f_pm && h < PM_SHIFT) h = h + PM_SHIFT;
      r.status = ST_PARTS;
      r.year_value = yr != 0 ? yr[13:0] : CENTURY_NEW;
      r.month_value = mon != 0 ? mon : 8'd1;
      r.day_value = dday != 0 ? dday : 8'd1;
      r.hour_value = h;
      r.minute_value = mnt;
      r.second_value = sec;
      r.zone_given = f_zone;
      r.zone_negative = f_neg;
      r.zone_hours = zh;
      r.zone_minutes = zm;
    end
    due_results.push_back(r);
    clear_parser();
  endfunction

  initial begin
    text_ch.valid = 1'b0;
    text_ch.payload = '0;
    result_ch.ready = 1'b0;
    clear_parser();
  end

  // Byte driver; the shadow parser advances on every accepted transfer.
  always @(posedge clk) begin
    if (rst) begin
      text_ch.valid <= 1'b0;
    end else begin
      if (text_ch.valid && text_ch.ready) predict_parse(text_ch.payload);
      if (!text_ch.valid || text_ch.ready) begin
        if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          text_ch.valid <= 1'b1;
          text_ch.payload <= byte_queue.pop_front();
        end else begin
          text_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (long_stall_req) begin
      result_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    dtp_out_t want, got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = result_ch.payload;
      results_seen++;
      if (due_results.size() == 0) begin
        $error("result transfer with nothing outstanding");
        error_count++;
      end else begin
        want = due_results.pop_front();
        if (want.status == ST_STAMP) stamps_seen++;
        if (want.status == ST_ERROR) errors_seen++;
        check_field("status", want.status, got.status);
        check_field("unix_seconds", want.unix_seconds, got.unix_seconds);
        check_field("year_value", want.year_value, got.year_value);
        check_field("month_value", want.month_value, got.month_value);
        check_field("day_value", want.day_value, got.day_value);
        check_field("hour_value", want.hour_value, got.hour_value);
        check_field("minute_value", want.minute_value, got.minute_value);
        check_field("second_value", want.second_value, got.second_value);
        check_field("zone_given", want.zone_given, got.zone_given);
        check_field("zone_negative", want.zone_negative, got.zone_negative);
        check_field("zone_hours", want.zone_hours, got.zone_hours);
        check_field("zone_minutes", want.zone_minutes, got.zone_minutes);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic add_num(int unsigned v, int n);
    int unsigned p;
    p = 1;
    for (int i = 1; i < n; i++) p = p * 10;
    for (int i = 0; i < n; i++) begin
      text_buf.push_back(8'(48 + (v / p) % 10));
      p = p / 10;
    end
  endtask

  task automatic add_digits(int n);
    for (int i = 0; i < n; i++) text_buf.push_back(8'(48 + $urandom_range(9)));
  endtask

  // Letters with randomly mixed case.
  task automatic add_word(string s);
    for (int i = 0; i < s.len(); i++)
      text_buf.push_back(s[i] ^ ($urandom_range(1) ? CASE_BIT : 8'h00));
  endtask

  task automatic send_text();
    dtp_in_t item;
    for (int i = 0; i < text_buf.size(); i++) begin
      item.text_byte = text_buf[i];
      item.final_byte = (i == text_buf.size() - 1);
      byte_queue.push_back(item);
    end
    if (text_buf.size() > 0) texts_sent++;
    bytes_sent += text_buf.size();
    text_buf.delete();
  endtask

  task automatic directed_text(string s);
    add_str(s);
    send_text();
  endtask

  task automatic add_zone();
    string names[4] = '{"GMT", "UTC", "MSK", "MSD"};
    case ($urandom_range(4))
      0: text_buf.push_back(CH_UPPER_Z);
      1: begin
        text_buf.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
        add_num($urandom_range(14), 2);
        text_buf.push_back(CH_COLON);
        add_num($urandom_range(59), 2);
      end
      2: begin
        text_buf.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
        add_digits($urandom_range(1, 5));
      end
      3: add_word(names[$urandom_range(3)]);
      default: ;
    endcase
  endtask

  task automatic random_text();
    string months[12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun", "Jul", "Aug",
                          "Sep", "Oct", "Nov", "Dec"};
    string days[7] = '{"Mon", "Tue", "Wed", "Thu", "Fri", "Sat", "Sun"};
    int kind;
    kind = $urandom_range(9);
    case (kind)
      0, 1: begin
        add_num($urandom_range(9999), 4);
        text_buf.push_back(CH_MINUS);
        add_num($urandom_range(99), 2);
        text_buf.push_back(CH_MINUS);
        add_num($urandom_range(99), 2);
        if ($urandom_range(3) != 0) begin
          text_buf.push_back($urandom_range(1) ? CH_UPPER_T : CH_SPACE);
          add_num($urandom_range(99), 2);
          text_buf.push_back(CH_COLON);
          add_num($urandom_range(99), 2);
          text_buf.push_back(CH_COLON);
          add_num($urandom_range(99), 2);
          if ($urandom_range(1)) begin
            text_buf.push_back(CH_POINT);
            add_digits($urandom_range(1, 16));
          end
          add_zone();
        end
      end
      2: begin
        if ($urandom_range(1)) begin
          add_word(days[$urandom_range(6)]);
          add_str(", ");
        end
        add_num($urandom_range(1, 31), $urandom_range(1, 2));
        text_buf.push_back(CH_SPACE);
        add_word(months[$urandom_range(11)]);
        text_buf.push_back(CH_SPACE);
        add_num($urandom_range(9999), 4);
        text_buf.push_back(CH_SPACE);
        add_num($urandom_range(23), 2);
        text_buf.push_back(CH_COLON);
        add_num($urandom_range(59), 2);
        text_buf.push_back(CH_COLON);
        add_num($urandom_range(59), 2);
        text_buf.push_back(CH_SPACE);
        add_zone();
      end
      3: begin
        add_num($urandom_range(99), $urandom_range(1, 2));
        text_buf.push_back(CH_SLASH);
        add_num($urandom_range(99), $urandom_range(1, 2));
        text_buf.push_back(CH_SLASH);
        add_num($urandom_range(9999), $urandom_range(1) ? 2 : 4);
        if ($urandom_range(1)) begin
          text_buf.push_back(CH_SPACE);
          add_num($urandom_range(12), 1);
          text_buf.push_back(CH_COLON);
          add_num($urandom_range(59), 2);
          text_buf.push_back(CH_SPACE);
          add_word($urandom_range(1) ? "PM" : "AM");
        end
      end
      4: add_digits($urandom_range(1) ? 14 : 8);
      5: add_digits($urandom_range(9, 10));
      6: begin
        add_num($urandom_range(99), $urandom_range(1, 2));
        text_buf.push_back(CH_COLON);
        add_num($urandom_range(99), 2);
        if ($urandom_range(1)) begin
          text_buf.push_back(CH_COLON);
          add_num($urandom_range(99), 2);
        end
        if ($urandom_range(1)) add_word($urandom_range(1) ? " pm" : " am");
      end
      7: begin
        add_digits($urandom_range(1, 16));
        if ($urandom_range(1)) add_word(months[$urandom_range(11)]);
      end
      default: begin
        for (int i = $urandom_range(1, 6); i > 0; i--) text_buf.push_back(8'($urandom_range(255)));
      end
    endcase
    // Some texts, well-formed or not, get one byte swapped for noise.
    if ($urandom_range(6) == 0 && text_buf.size() > 0)
      text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom_range(255));
    send_text();
  endtask

  task automatic wait_drained();
    while (byte_queue.size() > 0 || text_ch.valid) @(posedge clk);
    while (due_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(int snd, int rcv);
    int target;
    @(negedge clk);
    send_idle_pct = snd;
    recv_stall_pct = rcv;
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) random_text();
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    directed_text("2023-01-15T12:34:56Z");
    directed_text("1700000000");
    directed_text("9999999999");
    directed_text("Mon, 15 Jan 2024 08:30:00 +0530");
    directed_text("12/31/99");
    directed_text("20230115123456");
    directed_text("2023-01-15 03:04:05 PM");
    directed_text("12:30:45.123-07:00");
    directed_text("2024,");
    directed_text("123");
    directed_text("xyz");
    directed_text(".5");
    directed_text("12 am");
    directed_text("Tue 9 MSD");
    directed_text("123456789012345");
    directed_text("2024-06 ~ 99");
    directed_text("7 Feb 2024 10:00 msk");
    directed_text("12:30 12:30");
    text_buf.push_back(8'h00);
    send_text();
    text_buf.push_back(8'hFF);
    send_text();
    add_str("1999");
    text_buf.push_back(8'h90);
    add_str("55");
    send_text();
    wait_drained();

    random_phase(0, 0);
    random_phase(45, 0);
    random_phase(0, 45);
    random_phase(15, 15);

    // Output held off for a long stretch while bytes keep coming.
    @(negedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cnt = 0;
    long_stall_req = 1'b1;
    for (int i = 0; i < 12; i++) random_text();
    while (hold_cnt < LONG_HOLD) @(posedge clk);
    @(negedge clk);
    long_stall_req = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Covered %0d texts, %0d bytes, %0d results (%0d timestamps, %0d errors).",
             texts_sent, bytes_sent, results_seen, stamps_seen, errors_seen);
    $display("Idle patterns: none, sender gaps, receiver stalls, both, long output hold.");
    if (error_count == 0 && due_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
